// ===== design/dcgs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcgs_pkg
// Shared types, codes and constants of the decimal counter glyph sequencer.
// ----------------------------------------------------------------------------
package dcgs_pkg;

	// default sizes handed down from the top level
	localparam int MAX_DIGITS_DEF = 8;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths
	localparam int FIELD_W    = 32;
	localparam int SLOT_W     = 5;
	localparam int GLYPH_W    = 4;
	localparam int COLOR_W    = 2;
	localparam int NDIG_W     = 4;
	localparam int THR_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// glyph codes
	localparam logic [GLYPH_W-1:0] GLYPH_ZERO  = 4'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 4'd10;
	localparam logic [GLYPH_W-1:0] GLYPH_SEP   = 4'd11;

	// colour codes
	localparam logic [COLOR_W-1:0] COL_NORMAL = 2'd0;
	localparam logic [COLOR_W-1:0] COL_BELOW  = 2'd1;
	localparam logic [COLOR_W-1:0] COL_ZERO   = 2'd2;

	// percentage scale of the threshold compare
	localparam logic [THR_W-1:0] PERCENT = 7'd100;

	// divide by ten: q = (v * RECIP10) >> RECIP_SHIFT, exact for v below 2^32
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_DIGITS  = 3'd0,
		REG_SHOW_MAX    = 3'd1,
		REG_COLOR_MODE  = 3'd2,
		REG_SHOW_ZEROES = 3'd3,
		REG_THRESHOLD   = 3'd4
	} cfg_reg_t;

	// register reset values
	localparam logic [NDIG_W-1:0] NUM_DIGITS_RST  = 4'd4;
	localparam logic              SHOW_MAX_RST    = 1'b1;
	localparam logic              COLOR_MODE_RST  = 1'b1;
	localparam logic              SHOW_ZEROES_RST = 1'b0;
	localparam logic [THR_W-1:0]  THRESHOLD_RST   = 7'd25;

	typedef struct packed {
		logic [NDIG_W-1:0] num_digits;
		logic              show_max;
		logic              color_mode;
		logic              show_zeroes;
		logic [THR_W-1:0]  threshold_percent;
	} cfg_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] current_value;
		logic signed [FIELD_W-1:0] max_value;
	} in_beat_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] color_sel;
		logic               last;
	} out_beat_t;

endpackage

// ===== design/dcgs_front.sv =====
// ----------------------------------------------------------------------------
// dcgs_front
// Takes refresh beats, works out the colour class and turns both values into
// decimal glyphs, one digit of each value per cycle, then hands the record on.
// ----------------------------------------------------------------------------
module dcgs_front import dcgs_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int ENTRY_W = 2 * MAX_DIGITS * GLYPH_W + COLOR_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_beat_t           in_beat,
	output logic               push,
	output logic [ENTRY_W-1:0] entry,
	input  logic               full
);

	localparam int IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int A_W     = VALUE_BITS + THR_W;
	localparam int GV_W    = MAX_DIGITS * GLYPH_W;
	localparam int LANES   = 2;
	localparam int L_CUR   = 0;
	localparam int L_MAX   = 1;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_DIGITS - 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic [IDX_W-1:0] cnt_q;

	logic [VALUE_BITS-1:0] w_q   [LANES];
	logic                  neg_q [LANES];
	logic [GV_W-1:0]       g_q   [LANES];

	logic           cur_le0_q;
	logic           mx_zero_q;
	logic           mx_neg_q;
	logic [A_W-1:0] a_q;
	logic [A_W-1:0] b_q;

	logic accept;
	logic [VALUE_BITS-1:0] cur_v;
	logic [VALUE_BITS-1:0] mx_v;
	logic [VALUE_BITS-1:0] mx_mag;
	logic [A_W-1:0]        a_in;
	logic [A_W-1:0]        b_in;

	logic [63:0]           prod   [LANES];
	logic [VALUE_BITS-1:0] quot   [LANES];
	logic [VALUE_BITS-1:0] rem    [LANES];
	logic                  lead   [LANES];
	logic [GLYPH_W-1:0]    gnew   [LANES];
	logic [GV_W-1:0]       g_next [LANES];
	logic [COLOR_W-1:0]    color;

	// handshake
	assign push     = (state_q == F_DONE) && !full;
	assign in_stall = !((state_q == F_IDLE) || push);
	assign accept   = in_valid && !in_stall;

	// input values taken at the configured width
	assign cur_v  = in_beat.current_value[VALUE_BITS-1:0];
	assign mx_v   = in_beat.max_value[VALUE_BITS-1:0];
	assign mx_mag = ~mx_v + VALUE_BITS'(1);

	// threshold products: 100*cur against thr*max, or against |max| when max < 0
	assign a_in = A_W'(cur_v) * A_W'(PERCENT);
	assign b_in = mx_v[VALUE_BITS-1] ? A_W'(mx_mag)
		: A_W'(cfg.threshold_percent) * A_W'(mx_v);

	// one decimal digit per lane per cycle
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod[l] = 64'(w_q[l]) * 64'(RECIP10);
			quot[l] = VALUE_BITS'(prod[l] >> RECIP_SHIFT);
			rem[l]  = w_q[l] - ((quot[l] << 3) + (quot[l] << 1));
			lead[l] = neg_q[l] || ((cnt_q != '0) && (w_q[l] == '0));
			if (lead[l]) begin
				gnew[l] = cfg.show_zeroes ? GLYPH_ZERO : GLYPH_BLANK;
			end else begin
				gnew[l] = rem[l][GLYPH_W-1:0];
			end
			g_next[l] = g_q[l] >> GLYPH_W;
			g_next[l][GV_W-1 -: GLYPH_W] = gnew[l];
		end
	end

	// colour class of the current digits
	always_comb begin
		color = COL_NORMAL;
		if (cfg.color_mode) begin
			if (cur_le0_q) begin
				color = COL_ZERO;
			end else if (mx_zero_q) begin
				color = COL_NORMAL;
			end else if (mx_neg_q) begin
				if ((cfg.threshold_percent != '0) || (a_q >= b_q))
					color = COL_BELOW;
			end else if (a_q < b_q) begin
				color = COL_BELOW;
			end
		end
	end

	assign entry = {color, g_q[L_MAX], g_q[L_CUR]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= '0;
					end
				end
				F_CONV: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == LAST_STEP)
						state_q <= F_DONE;
				end
				F_DONE: begin
					if (push) begin
						state_q <= accept ? F_CONV : F_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= F_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// working values and glyph shift registers
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q[L_CUR]   <= cur_v[VALUE_BITS-1] ? '0 : cur_v;
			w_q[L_MAX]   <= mx_v[VALUE_BITS-1] ? '0 : mx_v;
			neg_q[L_CUR] <= cur_v[VALUE_BITS-1];
			neg_q[L_MAX] <= mx_v[VALUE_BITS-1];
			cur_le0_q    <= cur_v[VALUE_BITS-1] || (cur_v == '0);
			mx_zero_q    <= (mx_v == '0);
			mx_neg_q     <= mx_v[VALUE_BITS-1];
			a_q          <= a_in;
			b_q          <= b_in;
		end else if (state_q == F_CONV) begin
			for (int l = 0; l < LANES; l++) begin
				w_q[l] <= quot[l];
				g_q[l] <= g_next[l];
			end
		end
	end

endmodule

// ===== design/dcgs_queue.sv =====
// ----------------------------------------------------------------------------
// dcgs_queue
// Short first-in first-out buffer of glyph records between front and back.
// ----------------------------------------------------------------------------
module dcgs_queue import dcgs_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] rdata,
	input  logic             pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rdata   = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== design/dcgs_back.sv =====
// ----------------------------------------------------------------------------
// dcgs_back
// Walks the display slots of the record at the queue head, one beat a cycle
// while out_stall is low, into a registered output stage.
// ----------------------------------------------------------------------------
module dcgs_back import dcgs_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int ENTRY_W = 2 * MAX_DIGITS * GLYPH_W + COLOR_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               head_valid,
	input  logic [ENTRY_W-1:0] head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output out_beat_t          out_beat
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int GV_W  = MAX_DIGITS * GLYPH_W;

	logic [MAX_DIGITS-1:0][GLYPH_W-1:0] gcur;
	logic [MAX_DIGITS-1:0][GLYPH_W-1:0] gmax;
	logic [COLOR_W-1:0] color;

	logic [NDIG_W-1:0] nd;
	logic [SLOT_W-1:0] nd5;
	logic [SLOT_W-1:0] total;
	logic [SLOT_W-1:0] k_q;
	logic [SLOT_W-1:0] idx5;
	logic [IDX_W-1:0]  idx;
	logic              in_cur;
	logic              is_sep;
	logic              is_last;
	logic              empty_item;
	logic              adv;
	logic              emit;
	logic              out_valid_q;
	out_beat_t         out_beat_q;
	out_beat_t         beat;

	assign gcur  = head[GV_W-1:0];
	assign gmax  = head[2*GV_W-1:GV_W];
	assign color = head[ENTRY_W-1 -: COLOR_W];

	// slot count of one refresh
	assign nd    = (cfg.num_digits > NDIG_W'(MAX_DIGITS)) ? NDIG_W'(MAX_DIGITS)
		: cfg.num_digits;
	assign nd5   = SLOT_W'(nd);
	assign total = cfg.show_max ? (nd5 + nd5 + SLOT_W'(1)) : nd5;

	// position inside the refresh
	assign in_cur     = (k_q < nd5);
	assign is_sep     = (k_q == nd5);
	assign is_last    = (k_q == total - SLOT_W'(1));
	assign empty_item = (total == '0);
	assign idx5       = in_cur ? (nd5 - SLOT_W'(1) - k_q) : (nd5 + nd5 - k_q);
	assign idx        = idx5[IDX_W-1:0];

	// handshake towards the output register
	assign adv  = !out_valid_q || !out_stall;
	assign emit = adv && head_valid && !empty_item;
	assign pop  = head_valid && (empty_item || (adv && is_last));

	// beat for the current slot
	always_comb begin
		beat.slot = k_q;
		beat.last = is_last;
		if (in_cur) begin
			beat.glyph     = gcur[idx];
			beat.color_sel = color;
		end else if (is_sep) begin
			beat.glyph     = GLYPH_SEP;
			beat.color_sel = COL_NORMAL;
		end else begin
			beat.glyph     = gmax[idx];
			beat.color_sel = COL_NORMAL;
		end
	end

	// slot counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit)
				k_q <= is_last ? '0 : k_q + SLOT_W'(1);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit)
			out_beat_q <= beat;
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule

// ===== design/decimal_counter_glyph_sequencer.sv =====
// ----------------------------------------------------------------------------
// decimal_counter_glyph_sequencer
// Turns refresh requests (current and maximum value) into a row of display
// glyphs with leading-digit blanking and a colour class for the current value.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_beat  (current_value, max_value)
//   out      output     out_valid/out_stall  out_beat (slot, glyph, colour, last)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// The front makes one divide-by-ten step per digit on both values, then hands
// the record off; it takes the next refresh while handing off.
// The back gives one beat per cycle while out_stall is low: num_digits beats
// (capped at MAX_DIGITS), or 2*num_digits+1 with show_max.
// Reset sets the registers to their defaults and empties queue and output stage.
// A stalled output holds its beat; the two-entry queue lets the front go on.
// ----------------------------------------------------------------------------
module decimal_counter_glyph_sequencer import dcgs_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_beat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_beat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ENTRY_W = 2 * MAX_DIGITS * GLYPH_W + COLOR_W;

	cfg_t               cfg_q;
	logic               push;
	logic               full;
	logic [ENTRY_W-1:0] entry;
	logic               head_valid;
	logic [ENTRY_W-1:0] head;
	logic               pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_digits        <= NUM_DIGITS_RST;
			cfg_q.show_max          <= SHOW_MAX_RST;
			cfg_q.color_mode        <= COLOR_MODE_RST;
			cfg_q.show_zeroes       <= SHOW_ZEROES_RST;
			cfg_q.threshold_percent <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_DIGITS:  cfg_q.num_digits        <= cfg_data[NDIG_W-1:0];
				REG_SHOW_MAX:    cfg_q.show_max          <= cfg_data[0];
				REG_COLOR_MODE:  cfg_q.color_mode        <= cfg_data[0];
				REG_SHOW_ZEROES: cfg_q.show_zeroes       <= cfg_data[0];
				REG_THRESHOLD:   cfg_q.threshold_percent <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// digit conversion and colour class
	dcgs_front #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.push     (push),
		.entry    (entry),
		.full     (full)
	);

	// record queue
	dcgs_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.full   (full),
		.valid  (head_valid),
		.rdata  (head),
		.pop    (pop)
	);

	// slot sequencing
	dcgs_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

endmodule
